### hw/rtl/tblos_pkg.sv
// ----------------------------------------------------------------------------
// tblos_pkg
// Shared constants, types and state codes of the torsion-bin log-odds scorer.
// ----------------------------------------------------------------------------
package tblos_pkg;

  localparam int BinDegrees   = 10;
  localparam int ResidueTypes = 20;
  localparam int CountBits    = 24;

  localparam int TableBins = 360 / BinDegrees;
  localparam int Bins      = TableBins * TableBins;
  localparam int Cells     = ResidueTypes * Bins;

  localparam int AngleW   = 15;
  localparam int TypeW    = 5;
  localparam int EnergyW  = 24;
  localparam int TotalW   = 32;
  localparam int BinAddrW = $clog2(Bins);
  localparam int CellW    = $clog2(Cells);
  localparam int TypeSelW = (ResidueTypes > 1) ? $clog2(ResidueTypes) : 1;

  localparam int LogFrac = 20;
  localparam int LogW    = 5 + LogFrac;
  localparam int AccW    = LogW + 3;
  localparam int MagW    = AccW - 1;
  localparam int ProdW   = MagW + 32;

  localparam logic [31:0] Ln2Q32 = 32'hB17217F8;

  typedef struct packed {
    logic                command;
    logic                ok;
    logic [TypeW-1:0]    rtype;
    logic [BinAddrW-1:0] bin_addr;
    logic [CellW-1:0]    cell_addr;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_status_t;

  typedef enum logic [3:0] {
    BkClear, BkIdle, BkRead, BkEval, BkLaunch, BkLog, BkMul, BkRound
  } back_state_e;

  typedef enum logic [1:0] {
    LgIdle, LgNorm, LgSquare, LgDone
  } log_state_e;

endpackage

### hw/rtl/tblos_intf.sv
// ----------------------------------------------------------------------------
// tblos_intf
// Request and response channels of the torsion-bin log-odds scorer.
// ----------------------------------------------------------------------------
interface tblos_req_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    command;
  logic        [tblos_pkg::TypeW-1:0]      residue_type;
  logic signed [tblos_pkg::AngleW-1:0]     phi_angle;
  logic signed [tblos_pkg::AngleW-1:0]     psi_angle;

  modport source (output valid, command, residue_type, phi_angle, psi_angle, input ready);
  modport sink   (input valid, command, residue_type, phi_angle, psi_angle, output ready);
endinterface

interface tblos_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [tblos_pkg::EnergyW-1:0] energy;
  logic                                saturated;

  modport source (output valid, energy, saturated, input ready);
  modport sink   (input valid, energy, saturated, output ready);
endinterface

### hw/rtl/tblos_front.sv
// ----------------------------------------------------------------------------
// tblos_front
// Takes requests, bins both angles and forms the table addresses.
// ----------------------------------------------------------------------------
module tblos_front (
  tblos_req_if.sink          req_i,
  input  logic               full_i,
  output logic               push_o,
  output tblos_pkg::item_t   item_o
);

  localparam int Recip  = (65536 + tblos_pkg::BinDegrees - 1) / tblos_pkg::BinDegrees;
  localparam int BinIdxW = $clog2(tblos_pkg::TableBins + 1);

  typedef struct packed {
    logic               ok;
    logic [BinIdxW-1:0] bin;
  } abin_t;

  function automatic abin_t angle_bin(input logic signed [tblos_pkg::AngleW-1:0] a);
    logic signed [16:0] s;
    logic [8:0]         d;
    logic [25:0]        p;
    logic [9:0]         b;
    abin_t              r;
    s = 17'(a) + 17'sd11520;
    d = s[16] ? 9'd0 : s[14:6];
    p = 26'(d) * 26'(Recip);
    b = p[25:16];
    r.ok  = (s > -17'sd64) && (b <= 10'(tblos_pkg::TableBins));
    r.bin = (b == 10'(tblos_pkg::TableBins)) ? BinIdxW'(tblos_pkg::TableBins - 1)
                                             : BinIdxW'(b);
    return r;
  endfunction

  abin_t x_bin, y_bin;
  logic  type_ok;
  logic [tblos_pkg::BinAddrW-1:0] bin_addr;

  always_comb begin
    x_bin    = angle_bin(req_i.phi_angle);
    y_bin    = angle_bin(req_i.psi_angle);
    type_ok  = 32'(req_i.residue_type) < tblos_pkg::ResidueTypes;
    bin_addr = tblos_pkg::BinAddrW'(32'(x_bin.bin) * tblos_pkg::TableBins + 32'(y_bin.bin));
    item_o.command   = req_i.command;
    item_o.ok        = type_ok && x_bin.ok && y_bin.ok;
    item_o.rtype     = req_i.residue_type;
    item_o.bin_addr  = bin_addr;
    item_o.cell_addr = tblos_pkg::CellW'(32'(req_i.residue_type) * tblos_pkg::Bins
                                         + 32'(bin_addr));
  end

  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

endmodule

### hw/rtl/tblos_queue.sv
// ----------------------------------------------------------------------------
// tblos_queue
// Two-entry request queue between the front and back ends.
// ----------------------------------------------------------------------------
module tblos_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tblos_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output tblos_pkg::item_t item_o
);

  tblos_pkg::item_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign item_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= item_i;
  end

endmodule

### hw/rtl/tblos_log.sv
// ----------------------------------------------------------------------------
// tblos_log
// Iterative log2 in Q.20: five normalize steps, then one squaring per bit.
// ----------------------------------------------------------------------------
module tblos_log (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [31:0]                 n_i,
  output logic                        done_o,
  output logic [tblos_pkg::LogW-1:0]  result_o
);

  tblos_pkg::log_state_e state_q, state_d;
  logic [31:0] m_q, m_d;
  logic [4:0]  k_q, k_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [tblos_pkg::LogFrac-1:0] frac_q, frac_d;
  logic [4:0]  sh;
  logic [31:0] hi_mask;
  logic [63:0] sq;
  logic [32:0] m2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tblos_pkg::LgIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    k_q    <= k_d;
    frac_q <= frac_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    k_d     = k_q;
    frac_d  = frac_q;
    sh      = 5'd16 >> cnt_q[2:0];
    hi_mask = ~(32'hFFFF_FFFF >> sh);
    sq      = 64'(m_q) * 64'(m_q);
    m2      = sq[63:31];
    done_o  = 1'b0;
    case (state_q)
      tblos_pkg::LgIdle: begin
        if (start_i) begin
          m_d     = (n_i == 32'd0) ? 32'd1 : n_i;
          k_d     = 5'd31;
          frac_d  = '0;
          cnt_d   = '0;
          state_d = tblos_pkg::LgNorm;
        end
      end
      tblos_pkg::LgNorm: begin
        if ((m_q & hi_mask) == 32'd0) begin
          m_d = m_q << sh;
          k_d = k_q - sh;
        end
        if (cnt_q == 5'd4) begin
          cnt_d   = '0;
          state_d = tblos_pkg::LgSquare;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      tblos_pkg::LgSquare: begin
        m_d    = m2[32] ? m2[32:1] : m2[31:0];
        frac_d = {frac_q[tblos_pkg::LogFrac-2:0], m2[32]};
        if (cnt_q == 5'(tblos_pkg::LogFrac - 1)) begin
          state_d = tblos_pkg::LgDone;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      tblos_pkg::LgDone: begin
        done_o  = 1'b1;
        state_d = tblos_pkg::LgIdle;
      end
      default: state_d = tblos_pkg::LgIdle;
    endcase
  end

  assign result_o = {k_q, frac_q};

endmodule

### hw/rtl/tblos_back.sv
// ----------------------------------------------------------------------------
// tblos_back
// Count memories, add read-modify-write and the energy sequencer.
// ----------------------------------------------------------------------------
module tblos_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  tblos_pkg::item_t        item_i,
  output logic                    pop_o,
  tblos_rsp_if.source             rsp_o,
  output tblos_pkg::back_status_t status_o
);

  localparam int Cb = tblos_pkg::CountBits;
  localparam int Tw = tblos_pkg::TotalW;

  logic [Cb-1:0] tbc_mem [tblos_pkg::Cells];
  logic [Cb-1:0] bt_mem  [tblos_pkg::Bins];
  logic [Cb-1:0] tbc_rd_q, bt_rd_q;

  tblos_pkg::back_state_e state_q, state_d;
  tblos_pkg::item_t       item_q, item_d;
  logic [tblos_pkg::CellW-1:0] clr_q, clr_d;
  logic [Tw-1:0] tt_q [tblos_pkg::ResidueTypes];
  logic [Tw-1:0] gt_q, gt_d, tt_sel;
  logic [1:0]    op_q, op_d;
  logic signed [tblos_pkg::AccW-1:0] acc_q, acc_d;
  logic [tblos_pkg::ProdW-1:0] prod_q, prod_d;
  logic          neg_q, neg_d;
  logic          out_valid_q, out_valid_d, sat_q, sat_d;
  logic signed [tblos_pkg::EnergyW-1:0] energy_q, energy_d;

  logic tbc_we, bt_we, tt_we, rd_en, log_start, log_done, hit_max;
  logic [tblos_pkg::CellW-1:0]    tbc_waddr;
  logic [tblos_pkg::BinAddrW-1:0] bt_waddr;
  logic [Cb-1:0] tbc_wdata, bt_wdata;
  logic [31:0]   log_n;
  logic [tblos_pkg::LogW-1:0] log_res;
  logic [tblos_pkg::TypeSelW-1:0] tsel;
  logic [tblos_pkg::MagW-1:0] mag;
  logic [tblos_pkg::ProdW:0]  rnd;
  logic [tblos_pkg::EnergyW-1:0] q;

  tblos_log u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .n_i      (log_n),
    .done_o   (log_done),
    .result_o (log_res)
  );

  always_ff @(posedge clk_i) begin
    if (tbc_we) tbc_mem[tbc_waddr] <= tbc_wdata;
    if (bt_we)  bt_mem[bt_waddr]   <= bt_wdata;
    if (rd_en) begin
      tbc_rd_q <= tbc_mem[item_q.cell_addr];
      bt_rd_q  <= bt_mem[item_q.bin_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tblos_pkg::BkClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      gt_q        <= Tw'(tblos_pkg::ResidueTypes + 1);
      for (int i = 0; i < tblos_pkg::ResidueTypes; i++) tt_q[i] <= Tw'(1);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      gt_q        <= gt_d;
      if (tt_we) tt_q[tsel] <= tt_sel + Tw'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    op_q     <= op_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    neg_q    <= neg_d;
    sat_q    <= sat_d;
    energy_q <= energy_d;
  end

  assign tsel    = item_q.rtype[tblos_pkg::TypeSelW-1:0];
  assign tt_sel  = tt_q[tsel];
  assign hit_max = (tbc_rd_q == '1) || (bt_rd_q == '1) || (tt_sel == '1) || (gt_q == '1);

  always_comb begin
    case (op_q)
      2'd0:    log_n = 32'(bt_rd_q);
      2'd1:    log_n = tt_sel;
      2'd2:    log_n = 32'(tbc_rd_q);
      default: log_n = gt_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    clr_d       = clr_q;
    gt_d        = gt_q;
    op_d        = op_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    energy_d    = energy_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    tbc_we      = 1'b0;
    bt_we       = 1'b0;
    tt_we       = 1'b0;
    tbc_waddr   = item_q.cell_addr;
    bt_waddr    = item_q.bin_addr;
    tbc_wdata   = tbc_rd_q + Cb'(1);
    bt_wdata    = bt_rd_q + Cb'(1);
    rd_en       = 1'b0;
    log_start   = 1'b0;
    pop_o       = 1'b0;
    mag         = acc_q[tblos_pkg::AccW-1] ? tblos_pkg::MagW'(-acc_q)
                                           : tblos_pkg::MagW'(acc_q);
    rnd         = (tblos_pkg::ProdW + 1)'(prod_q) + ((tblos_pkg::ProdW + 1)'(1) << 35);
    q           = rnd[36 +: tblos_pkg::EnergyW];
    case (state_q)
      tblos_pkg::BkClear: begin
        tbc_we    = 1'b1;
        tbc_waddr = clr_q;
        tbc_wdata = Cb'(1);
        bt_we     = 32'(clr_q) < tblos_pkg::Bins;
        bt_waddr  = clr_q[tblos_pkg::BinAddrW-1:0];
        bt_wdata  = Cb'(tblos_pkg::ResidueTypes + 1);
        if (32'(clr_q) == tblos_pkg::Cells - 1) state_d = tblos_pkg::BkIdle;
        else clr_d = clr_q + 1'b1;
      end
      tblos_pkg::BkIdle: begin
        if (valid_i && !out_valid_q) begin
          pop_o  = 1'b1;
          item_d = item_i;
          if (item_i.ok) begin
            state_d = tblos_pkg::BkRead;
          end else begin
            out_valid_d = 1'b1;
            energy_d    = '0;
            sat_d       = 1'b0;
          end
        end
      end
      tblos_pkg::BkRead: begin
        rd_en   = 1'b1;
        state_d = tblos_pkg::BkEval;
      end
      tblos_pkg::BkEval: begin
        if (!item_q.command) begin
          if (!hit_max) begin
            tbc_we = 1'b1;
            bt_we  = 1'b1;
            tt_we  = 1'b1;
            gt_d   = gt_q + Tw'(1);
          end
          out_valid_d = 1'b1;
          energy_d    = '0;
          sat_d       = hit_max;
          state_d     = tblos_pkg::BkIdle;
        end else begin
          op_d    = 2'd0;
          acc_d   = '0;
          state_d = tblos_pkg::BkLaunch;
        end
      end
      tblos_pkg::BkLaunch: begin
        log_start = 1'b1;
        state_d   = tblos_pkg::BkLog;
      end
      tblos_pkg::BkLog: begin
        if (log_done) begin
          if (op_q[1]) acc_d = acc_q - tblos_pkg::AccW'(log_res);
          else         acc_d = acc_q + tblos_pkg::AccW'(log_res);
          if (op_q == 2'd3) begin
            state_d = tblos_pkg::BkMul;
          end else begin
            op_d    = op_q + 2'd1;
            state_d = tblos_pkg::BkLaunch;
          end
        end
      end
      tblos_pkg::BkMul: begin
        prod_d  = tblos_pkg::ProdW'(mag) * tblos_pkg::ProdW'(tblos_pkg::Ln2Q32);
        neg_d   = acc_q[tblos_pkg::AccW-1];
        state_d = tblos_pkg::BkRound;
      end
      tblos_pkg::BkRound: begin
        if (neg_q) begin
          energy_d = (q > 24'd8388608) ? 24'sh800000 : -$signed(q);
        end else begin
          energy_d = (q > 24'd8388607) ? 24'sh7FFFFF : $signed(q);
        end
        sat_d       = 1'b0;
        out_valid_d = 1'b1;
        state_d     = tblos_pkg::BkIdle;
      end
      default: state_d = tblos_pkg::BkIdle;
    endcase
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.energy    = energy_q;
  assign rsp_o.saturated = sat_q;

  assign status_o.clearing = state_q == tblos_pkg::BkClear;
  assign status_o.busy     = state_q != tblos_pkg::BkIdle;

endmodule

### hw/rtl/torsion_bin_log_odds_scorer_core.sv
// ----------------------------------------------------------------------------
// torsion_bin_log_odds_scorer_core
// Per-residue (phi, psi) histograms with log-odds energy queries.
// ----------------------------------------------------------------------------
// After reset the block sweeps its count memories, one cell per cycle, across
// all 25920 cells before it serves any request; requests are queued (two deep)
// meanwhile. With an idle back end, an add is dequeued, then its counts are
// read, checked and written back. A query is dequeued, read and checked, then
// makes four passes through the shared log2 unit, which squares once per result
// bit, then a multiply step and a rounding step. Requests with an out-of-range
// type or angle answer straight from dequeue. Results leave through an output
// register, and a response still waiting there holds off the next request.
module torsion_bin_log_odds_scorer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tblos_req_if.sink   req_i,
  tblos_rsp_if.source rsp_o
);

  logic                   push, full, pop, q_valid;
  tblos_pkg::item_t       front_item, q_item;
  tblos_pkg::back_status_t status;

  tblos_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  tblos_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  tblos_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .item_i   (q_item),
    .pop_o    (pop),
    .rsp_o    (rsp_o),
    .status_o (status)
  );

  a_no_rsp_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.clearing |-> !rsp_o.valid)
    else $error("response during clear sweep");

  a_sat_has_zero_energy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.saturated) |-> (rsp_o.energy == '0))
    else $error("saturated add carries energy");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !status.busy && q_valid)
    else $error("queue popped while back end busy");

endmodule

### tb/tblos_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tblos_scoreboard
// Watches the request and response channels of the torsion-bin log-odds
// scorer, predicts each response from its own copy of the histograms and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tblos_scoreboard
  import tblos_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tblos_req_if        req_i,
  tblos_rsp_if        rsp_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [EnergyW-1:0] energy;
    logic               saturated;
  } score_t;

  localparam logic [31:0] CountMax = 32'((64'd1 << CountBits) - 1);
  localparam logic [31:0] TotalMax = 32'hFFFF_FFFF;

  logic [31:0] hist_q     [Cells];
  logic [31:0] bin_sum_q  [Bins];
  logic [31:0] type_sum_q [ResidueTypes];
  logic [31:0] all_sum_q;
  score_t      scores_due [$];

  function automatic int angle_to_bin(logic signed [AngleW-1:0] a);
    int s, d, b;
    s = int'(a) + 180 * 64;
    if (s <= -64) return -1;
    d = (s < 0) ? 0 : (s >>> 6);
    b = d / BinDegrees;
    if (b == TableBins) b = TableBins - 1;
    if (b > TableBins) return -1;
    return b;
  endfunction

  function automatic longint log2_q20(logic [31:0] n);
    longint unsigned m;
    longint          res;
    int              k;
    if (n == 0) n = 1;
    k = 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    m = longint'(n) << (31 - k);
    res = longint'(k) << LogFrac;
    for (int i = LogFrac - 1; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= (64'd1 << 32)) begin
        res += longint'(1) << i;
        m = m >> 1;
      end
    end
    return res;
  endfunction

  function automatic logic [EnergyW-1:0] log_odds(logic [31:0] b, logic [31:0] bt,
                                                  logic [31:0] t, logic [31:0] gt);
    longint          s;
    longint unsigned mag, q;
    longint          e;
    s = log2_q20(bt) + log2_q20(t) - log2_q20(b) - log2_q20(gt);
    mag = (s < 0) ? -s : s;
    q = (mag * 64'hB17217F8 + (64'd1 << 35)) >> 36;
    if (s < 0) e = (q > 8388608) ? -8388608 : -longint'(q);
    else       e = (q > 8388607) ? 8388607 : longint'(q);
    return e[EnergyW-1:0];
  endfunction

  function automatic score_t apply_request(logic cmd, logic [TypeW-1:0] rt,
                                           logic signed [AngleW-1:0] phi,
                                           logic signed [AngleW-1:0] psi);
    score_t r;
    int x, y, bi, ci;
    r = '0;
    x = angle_to_bin(phi);
    y = angle_to_bin(psi);
    if (rt >= ResidueTypes || x < 0 || y < 0) return r;
    bi = x * TableBins + y;
    ci = int'(rt) * Bins + bi;
    if (cmd) begin
      r.energy = log_odds(hist_q[ci], bin_sum_q[bi], type_sum_q[rt], all_sum_q);
    end else if (hist_q[ci] >= CountMax || bin_sum_q[bi] >= CountMax ||
                 type_sum_q[rt] >= TotalMax || all_sum_q >= TotalMax) begin
      r.saturated = 1'b1;
    end else begin
      hist_q[ci]++;
      bin_sum_q[bi]++;
      type_sum_q[rt]++;
      all_sum_q++;
    end
    return r;
  endfunction

  initial begin
    foreach (hist_q[i]) hist_q[i] = 1;
    foreach (bin_sum_q[i]) bin_sum_q[i] = ResidueTypes + 1;
    foreach (type_sum_q[i]) type_sum_q[i] = 1;
    all_sum_q = ResidueTypes + 1;
    errors_o  = 0;
  end

  assign pending_o = scores_due.size();

  always @(posedge clk_i) begin
    score_t want;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (scores_due.size() == 0) begin
          $error("response with nothing outstanding: energy %0d saturated %0b",
                 rsp_i.energy, rsp_i.saturated);
          errors_o++;
        end else begin
          want = scores_due.pop_front();
          if (rsp_i.energy !== want.energy) begin
            $error("energy: expected %0d, got %0d",
                   $signed(want.energy), rsp_i.energy);
            errors_o++;
          end
          if (rsp_i.saturated !== want.saturated) begin
            $error("saturated: expected %0b, got %0b", want.saturated, rsp_i.saturated);
            errors_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        scores_due.insert(scores_due.size(),
                          apply_request(req_i.command, req_i.residue_type,
                                        req_i.phi_angle, req_i.psi_angle));
    end
  end

endmodule

### tb/tb_torsion_bin_log_odds_scorer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_torsion_bin_log_odds_scorer_core
// Drives adds and energy queries into the scorer: directed angle and type
// edge cases, then random requests clustered on a few bins so counts grow,
// with random idling on both channels, one long response stall and one
// drain pause. A scoreboard predicts and checks every response.
// ----------------------------------------------------------------------------
module tb_torsion_bin_log_odds_scorer_core;
  import tblos_pkg::*;

  localparam int RandReqs = 1930;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;

  tblos_req_if req ();
  tblos_rsp_if rsp ();

  torsion_bin_log_odds_scorer_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  tblos_scoreboard sb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rsp_i     (rsp),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #30ms;
    $display("FAIL torsion_bin_log_odds_scorer_core");
    $finish;
  end

  // ready only moves at the rising edge, so its value at the falling edge
  // is the one the next rising edge sees
  task automatic send(logic cmd, logic [TypeW-1:0] rt, logic [AngleW-1:0] phi,
                      logic [AngleW-1:0] psi);
    @(negedge clk_i);
    req.valid        = 1'b1;
    req.command      = cmd;
    req.residue_type = rt;
    req.phi_angle    = phi;
    req.psi_angle    = psi;
    while (!req.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle_req(int n);
    @(negedge clk_i);
    req.valid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic logic [AngleW-1:0] pick_angle();
    int sel, hot;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      hot = $urandom_range(0, 3);
      case (hot)
        0:       return AngleW'(-63 * 64 + $urandom_range(0, 1279));
        1:       return AngleW'(-41 * 64 + $urandom_range(0, 639));
        2:       return AngleW'(120 * 64 + $urandom_range(0, 1279));
        default: return AngleW'(170 * 64 + $urandom_range(0, 1279));
      endcase
    end
    if (sel < 90) return AngleW'($urandom_range(0, 23040) - 11520);
    return AngleW'($urandom_range(0, 32767));
  endfunction

  function automatic logic [TypeW-1:0] pick_type();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return TypeW'($urandom_range(0, 3));
    if (sel < 92) return TypeW'($urandom_range(0, ResidueTypes - 1));
    return TypeW'($urandom_range(0, 31));
  endfunction

  // response side: random bursts of backpressure, one long stall on request
  initial begin
    int n;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rsp.ready = 1'b0;
        n = 0;
        while (n < 400) begin
          @(negedge clk_i);
          n++;
        end
        hold_req = 1'b0;
        rsp.ready = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else begin
        rsp.ready = 1'b1;
      end
    end
  end

  initial begin
    int n;
    req.valid        = 1'b0;
    req.command      = 1'b0;
    req.residue_type = '0;
    req.phi_angle    = '0;
    req.psi_angle    = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: angle edges, invalid angles and types, repeat adds then query
    send(1'b1, 5'd0, -15'sd11520, -15'sd11520);
    send(1'b0, 5'd0, -15'sd11520, 15'sd11520);
    send(1'b1, 5'd0, -15'sd11520, 15'sd11520);
    send(1'b0, 5'd19, 15'sd12159, -15'sd11521);
    send(1'b1, 5'd19, 15'sd12159, -15'sd11521);
    send(1'b0, 5'd1, 15'sd12160, 15'sd0);
    send(1'b1, 5'd1, 15'sd0, 15'sd12160);
    send(1'b0, 5'd2, -15'sd11584, 15'sd0);
    send(1'b1, 5'd2, 15'sd0, -15'sd11584);
    send(1'b0, 5'd2, -15'sd11583, 15'sd0);
    send(1'b0, 5'd20, 15'sd0, 15'sd0);
    send(1'b1, 5'd31, 15'sd0, 15'sd0);
    send(1'b0, 5'd3, -15'sd16384, 15'sd16383);
    send(1'b1, 5'd3, 15'sd16383, -15'sd16384);
    for (int i = 0; i < 5; i++) send(1'b0, 5'd4, 15'sd640, -15'sd640);
    send(1'b1, 5'd4, 15'sd640, -15'sd640);
    send(1'b1, 5'd5, 15'sd640, -15'sd640);
    send(1'b1, 5'd4, 15'sd0, 15'sd0);
    send(1'b1, 5'd0, -15'sd11520, 15'sd11520);

    for (int i = 0; i < RandReqs; i++) begin
      if (i == 500) hold_req = 1'b1;
      if (i == 1100) begin
        idle_req(1);
        do @(posedge clk_i); while (pending != 0);
      end
      if (i == RandReqs - 300) quiet = 1'b1;
      send(1'($urandom_range(0, 1)), pick_type(), pick_angle(), pick_angle());
      if (!quiet && $urandom_range(0, 4) == 0) idle_req($urandom_range(1, 4));
    end
    idle_req(1);

    n = 0;
    while (pending != 0 && n < 100000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS torsion_bin_log_odds_scorer_core");
    end else begin
      $display("FAIL torsion_bin_log_odds_scorer_core");
    end
    $finish;
  end

endmodule
